// ===== design/llc_pkg.sv =====
// Shared types and constants of the lead-lag compensator.
`timescale 1ns / 1ps
package llc_pkg;

  localparam int CFG_W     = 32;
  localparam int POLE_W    = 31;
  localparam int TS_W      = 16;
  localparam int DIGIT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int AT_W      = CFG_W + TS_W;
  localparam int BT_W      = POLE_W + TS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_RATE   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MGO,
    ST_MWAIT,
    ST_MAG,
    ST_DGO,
    ST_DWAIT,
    ST_OUT
  } llc_state_e;

  // Products in the order the sequencer runs them.
  typedef enum logic [2:0] {
    OP_GAIN,
    OP_LEAD,
    OP_AT,
    OP_BT,
    OP_NY,
    OP_NX,
    OP_NXP
  } llc_op_e;

  typedef struct packed {
    logic    ld_in;
    logic    mul_go;
    logic    post;
    llc_op_e op;
    logic    ld_mag;
    logic    div_go;
    logic    ld_out;
  } llc_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } llc_sts_t;

endpackage

// ===== design/lead_lag_compensator_unit.sv =====
// Top level of the first-order bilinear lead-lag compensator.
`timescale 1ns / 1ps
// Each item takes a raw sample and a time step and returns one filtered value and
// a clip flag. The block takes one item at a time; how long an item occupies it
// is set by the one shared multiplier, which takes one 16-bit digit per cycle for
// each of the seven products, and by the divider, which yields one quotient bit
// per cycle; a quotient that overflows skips the division steps. A finished result
// sits in the output register while the next item is accepted and processed.
module lead_lag_compensator_unit #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [llc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [llc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]       raw_sample_i,
  input  logic [llc_pkg::TS_W-1:0]      time_step_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]       filtered_value_o,
  output logic                          clipped_o
);
  import llc_pkg::*;

  llc_cmd_t cmd;
  llc_sts_t sts;

  llc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  llc_datapath #(
    .W (SAMPLE_WIDTH),
    .F (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .raw_sample_i     (raw_sample_i),
    .time_step_i      (time_step_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .filtered_value_o (filtered_value_o),
    .clipped_o        (clipped_o)
  );

  // An accepted item makes the block busy and starts the first product.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && cmd.mul_go))
    else $error("accepted item did not start the multiply sequence");

  // A new result never overwrites one that is still waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ld_out && out_valid_o) |-> out_ready_i)
    else $error("result register overwritten before it was taken");

  // A taken result with nothing new behind it clears the output valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !cmd.ld_out) |=> !out_valid_o)
    else $error("result repeated after it was taken");

  // The multiplier and divider are never started while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!cmd.mul_go && !cmd.div_go && !sts.mul_done && !sts.div_done))
    else $error("arithmetic unit active while idle");

endmodule

// ===== design/llc_mul.sv =====
// Shared sign-magnitude multiplier, one 16-bit digit of the second operand per cycle.
`timescale 1ns / 1ps
module llc_mul #(
  parameter int AW = 49,
  parameter int BW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AW-1:0]        a_i,
  input  logic [BW-1:0]        b_i,
  output logic                 done_o,
  output logic [AW+((BW+llc_pkg::DIGIT_W-1)/llc_pkg::DIGIT_W)*llc_pkg::DIGIT_W-1:0] mag_o,
  output logic                 neg_o
);
  import llc_pkg::*;

  localparam int ND    = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int BPW   = ND * DIGIT_W;
  localparam int PW    = AW + BPW;
  localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;

  logic [AW-1:0]         ma_q, ma_d;
  logic [BPW-1:0]        mb_q, mb_d;
  logic [PW-1:0]         acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [AW+DIGIT_W-1:0] part;
  logic [AW+DIGIT_W-1:0] sum;
  logic [AW-1:0]         a_abs;
  logic [BW-1:0]         b_abs;

  assign a_abs = a_i[AW-1] ? (~a_i + AW'(1)) : a_i;
  assign b_abs = b_i[BW-1] ? (~b_i + BW'(1)) : b_i;
  assign part  = (AW+DIGIT_W)'(ma_q) * (AW+DIGIT_W)'(mb_q[DIGIT_W-1:0]);
  assign sum   = (AW+DIGIT_W)'(acc_q[PW-1:BPW]) + part;

  always_comb begin
    ma_d   = ma_q;
    mb_d   = mb_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      ma_d   = a_abs;
      mb_d   = BPW'(b_abs);
      acc_d  = '0;
      neg_d  = a_i[AW-1] ^ b_i[BW-1];
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      // The accumulator shifts right one digit as each partial product lands.
      acc_d = {sum, acc_q[BPW-1:DIGIT_W]};
      mb_d  = mb_q >> DIGIT_W;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ND - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign mag_o  = acc_q;
  assign neg_o  = neg_q;

endmodule

// ===== design/llc_div.sv =====
// Restoring divider, one quotient bit per cycle, with an up-front overflow test.
`timescale 1ns / 1ps
module llc_div #(
  parameter int NW = 81,
  parameter int DW = 48,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int SHW   = DW + QW;
  localparam int CNT_W = $clog2(QW);

  logic [DW-1:0]    den_q, den_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    low_q, low_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW:0]      r2;
  logic [DW:0]      diff;
  logic             ge;
  logic             ovf_start;

  // A quotient of 2^QW or more saturates anyway, so only QW bits are developed.
  assign ovf_start = NW'(num_i) >= NW'({den_i, {QW{1'b0}}});
  assign r2        = {rem_q, low_q[QW-1]};
  assign ge        = r2 >= {1'b0, den_q};
  assign diff      = r2 - {1'b0, den_q};

  always_comb begin
    den_d  = den_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      den_d  = den_i;
      rem_d  = num_i[SHW-1:QW];
      low_d  = num_i[QW-1:0];
      quo_d  = '0;
      ovf_d  = ovf_start;
      cnt_d  = '0;
      busy_d = !ovf_start;
      done_d = ovf_start;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : r2[DW-1:0];
      low_d = low_q << 1;
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

// ===== design/llc_datapath.sv =====
// Datapath: configuration, filter state, operand selection, rounding and saturation.
`timescale 1ns / 1ps
module llc_datapath #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [llc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [llc_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [W-1:0]                   raw_sample_i,
  input  logic [llc_pkg::TS_W-1:0]       time_step_i,
  input  llc_pkg::llc_cmd_t              cmd_i,
  output llc_pkg::llc_sts_t              sts_o,
  output logic [W-1:0]                   filtered_value_o,
  output logic                           clipped_o
);
  import llc_pkg::*;

  localparam int CW   = (F + 19 > 49) ? F + 19 : 49;
  localparam int DW   = CW - 1;
  localparam int AW   = (CW > W) ? CW : W;
  localparam int BW   = (W > CFG_W) ? W : CFG_W;
  localparam int ND   = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int PW   = AW + ND * DIGIT_W;
  localparam int SV   = PW + 2;
  localparam int RMW  = PW + 1 - F;
  localparam int NSW  = CW + W + 1;

  localparam logic [CFG_W-1:0] GAIN_RST = CFG_W'(1) << F;
  localparam logic [CW-1:0]    TWO_C    = CW'(1) << (F + TS_W + 1);
  localparam logic [DW-1:0]    TWO_D    = DW'(1) << (F + TS_W + 1);
  localparam logic [PW:0]      HALF_F   = (PW + 1)'(1) << (F - 1);
  localparam logic [W-1:0]     MIN_W    = W'(1) << (W - 1);
  localparam logic [W-1:0]     MAX_W    = ~MIN_W;

  // Configuration and filter state.
  logic [CFG_W-1:0]  gain_q, offset_q, lead_q, zero_q;
  logic [POLE_W-1:0] pole_q;
  logic [W-1:0]      last_x_q, last_y_q;

  // Per-item working registers.
  logic [W-1:0]      raw_q, u_q, x_q;
  logic [TS_W-1:0]   dt_q;
  logic [AT_W-1:0]   at_q;
  logic [BT_W-1:0]   bt_q;
  logic [NSW-1:0]    num_q, mag_q;
  logic              num_neg_q;
  logic              clip_q;
  logic [W-1:0]      out_val_q;
  logic              out_clip_q;

  logic [CW-1:0]     at_x, bt_x, c0, c1, c2;
  logic [DW-1:0]     den;
  logic [AW-1:0]     mul_a;
  logic [BW-1:0]     mul_b;
  logic [PW-1:0]     mul_mag;
  logic              mul_neg;
  logic              mul_done;
  logic [PW:0]       rm_full;
  logic [RMW-1:0]    rm;
  logic [SV-1:0]     rm_x, off_x, vsum;
  logic [SV-W:0]     vtop;
  logic              fits;
  logic [W-1:0]      sat_v;
  logic [NSW-1:0]    m_n, num_base, num_d;
  logic [AT_W-1:0]   m_a, at_d;
  logic              nneg;
  logic [NSW-1:0]    mag_d;
  logic [W-1:0]      quo;
  logic              ovf;
  logic              div_done;
  logic              y_clip;
  logic [W-1:0]      y_val;

  // Coefficients 2 - bT, aT + 2 and aT - 2, and the denominator 2 + bT.
  assign at_x = CW'(signed'(at_q));
  assign bt_x = CW'(bt_q);
  assign c0   = TWO_C - bt_x;
  assign c1   = at_x + TWO_C;
  assign c2   = at_x - TWO_C;
  assign den  = TWO_D + DW'(bt_q);

  always_comb begin
    case (cmd_i.op)
      OP_GAIN: begin
        mul_a = AW'(signed'(raw_q));
        mul_b = BW'(signed'(gain_q));
      end
      OP_LEAD: begin
        mul_a = AW'(signed'(u_q));
        mul_b = BW'(signed'(lead_q));
      end
      OP_AT: begin
        mul_a = AW'(signed'(zero_q));
        mul_b = BW'(dt_q);
      end
      OP_BT: begin
        mul_a = AW'(pole_q);
        mul_b = BW'(dt_q);
      end
      OP_NY: begin
        mul_a = AW'(signed'(c0));
        mul_b = BW'(signed'(last_y_q));
      end
      OP_NX: begin
        mul_a = AW'(signed'(c1));
        mul_b = BW'(signed'(x_q));
      end
      OP_NXP: begin
        mul_a = AW'(signed'(c2));
        mul_b = BW'(signed'(last_x_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  llc_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .mag_o   (mul_mag),
    .neg_o   (mul_neg)
  );

  // Round the magnitude half away from zero, then restore the sign by adding
  // the ones' complement with a carry in, folding in the offset on the same adder.
  assign rm_full = (PW + 1)'(mul_mag) + HALF_F;
  assign rm      = rm_full[PW:F];
  assign rm_x    = SV'(rm);
  assign off_x   = (cmd_i.op == OP_GAIN) ? SV'(signed'(offset_q)) : '0;
  assign vsum    = off_x + (mul_neg ? ~rm_x : rm_x) + SV'(mul_neg);
  assign vtop    = vsum[SV-1:W-1];
  assign fits    = (&vtop) | ~(|vtop);
  assign sat_v   = fits ? vsum[W-1:0] : (vsum[SV-1] ? MIN_W : MAX_W);

  assign m_n      = NSW'(mul_mag);
  assign num_base = (cmd_i.op == OP_NY) ? '0 : num_q;
  assign num_d    = num_base + (mul_neg ? ~m_n : m_n) + NSW'(mul_neg);
  assign m_a      = AT_W'(mul_mag);
  assign at_d     = (mul_neg ? ~m_a : m_a) + AT_W'(mul_neg);

  // Magnitude of the numerator plus half the denominator, ready to divide.
  assign nneg  = num_q[NSW-1];
  assign mag_d = (nneg ? ~num_q : num_q) + NSW'(den >> 1) + NSW'(nneg);

  llc_div #(
    .NW (NSW),
    .DW (DW),
    .QW (W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (mag_q),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo),
    .ovf_o   (ovf)
  );

  always_comb begin
    if (num_neg_q) begin
      y_clip = ovf | (quo[W-1] & (|quo[W-2:0]));
      y_val  = y_clip ? MIN_W : (~quo + W'(1));
    end else begin
      y_clip = ovf | quo[W-1];
      y_val  = y_clip ? MAX_W : quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      offset_q <= '0;
      lead_q   <= '0;
      zero_q   <= '0;
      pole_q   <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INPUT_GAIN:   gain_q   <= cfg_data_i;
          CFG_INPUT_OFFSET: offset_q <= cfg_data_i;
          CFG_LEAD_GAIN:    lead_q   <= cfg_data_i;
          CFG_ZERO_RATE:    zero_q   <= cfg_data_i;
          CFG_POLE_RATE:    pole_q   <= cfg_data_i[POLE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.ld_out) begin
        last_x_q <= x_q;
        last_y_q <= y_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      raw_q  <= raw_sample_i;
      dt_q   <= time_step_i;
      clip_q <= 1'b0;
    end
    if (cmd_i.post) begin
      case (cmd_i.op)
        OP_GAIN: begin
          u_q    <= sat_v;
          clip_q <= clip_q | ~fits;
        end
        OP_LEAD: begin
          x_q    <= sat_v;
          clip_q <= clip_q | ~fits;
        end
        OP_AT:   at_q  <= at_d;
        OP_BT:   bt_q  <= mul_mag[BT_W-1:0];
        default: num_q <= num_d;
      endcase
    end
    if (cmd_i.ld_mag) begin
      mag_q     <= mag_d;
      num_neg_q <= nneg;
    end
    if (cmd_i.ld_out) begin
      out_val_q  <= y_val;
      out_clip_q <= clip_q | y_clip;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign filtered_value_o = out_val_q;
  assign clipped_o        = out_clip_q;

endmodule

// ===== design/llc_ctrl.sv =====
// Controller: sequences the seven products, the divide and the output register.
`timescale 1ns / 1ps
module llc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  llc_pkg::llc_sts_t sts_i,
  output llc_pkg::llc_cmd_t cmd_o
);
  import llc_pkg::*;

  llc_state_e state_q, state_d;
  llc_op_e    phase_q, phase_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= OP_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = phase_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          phase_d     = OP_GAIN;
          state_d     = ST_MGO;
        end
      end
      ST_MGO: begin
        cmd_o.mul_go = 1'b1;
        state_d      = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.post = 1'b1;
          state_d    = ST_MGO;
          case (phase_q)
            OP_GAIN: phase_d = OP_LEAD;
            OP_LEAD: phase_d = OP_AT;
            OP_AT:   phase_d = OP_BT;
            OP_BT:   phase_d = OP_NY;
            OP_NY:   phase_d = OP_NX;
            OP_NX:   phase_d = OP_NXP;
            default: state_d = ST_MAG;
          endcase
        end
      end
      ST_MAG: begin
        cmd_o.ld_mag = 1'b1;
        state_d      = ST_DGO;
      end
      ST_DGO: begin
        cmd_o.div_go = 1'b1;
        state_d      = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // The result waits here only while the previous one is still held.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/lead_lag_compensator_unit_tb.sv =====
// Self-checking testbench for the lead-lag compensator unit.
`timescale 1ns / 1ps
module lead_lag_compensator_unit_tb;

  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;

  localparam logic [llc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE_Q16 = 32'hFFFF_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  localparam logic signed [127:0] Q_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;
  // The constant 2.0 with 32 fraction bits, as the rate-times-step terms use.
  localparam logic signed [127:0] TWO_Q32 = 128'sh2_0000_0000;

  typedef struct packed {
    logic [31:0] raw;
    logic [15:0] dt;
  } sample_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        clip;
  } filt_res_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [llc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [llc_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [SAMPLE_W-1:0]           raw_sample_i = '0;
  logic [llc_pkg::TS_W-1:0]      time_step_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0]           filtered_value_o;
  logic                          clipped_o;

  lead_lag_compensator_unit #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .FRAC_BITS   (FRAC_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .raw_sample_i    (raw_sample_i),
    .time_step_i     (time_step_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .filtered_value_o(filtered_value_o),
    .clipped_o       (clipped_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Local copy of the registers and of the filter memory.
  logic [31:0] gain_reg = ONE_Q16;
  logic [31:0] offset_reg = '0;
  logic [31:0] lead_reg = '0;
  logic [31:0] zero_reg = '0;
  logic [30:0] pole_reg = '0;
  logic [31:0] prev_scaled = '0;
  logic [31:0] prev_filtered = '0;

  sample_item_t pending_samples[$];
  filt_res_t    expected_outputs[$];
  int unsigned  mismatch_count = 0;
  int unsigned  in_gap_pct = 0;
  int unsigned  out_stall_pct = 0;
  logic         sample_taken = 1'b0;

  function automatic logic signed [127:0] sx32(input logic [31:0] v);
    return $signed({{96{v[31]}}, v});
  endfunction

  // Drops the fraction bits of a product, rounding half away from zero.
  function automatic logic signed [127:0] round_shift(input logic signed [127:0] v);
    logic [127:0] mag;
    mag = v[127] ? -v : v;
    mag = (mag + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
    return v[127] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [127:0] v, output logic hit);
    hit = 1'b1;
    if (v > Q_MAX) begin
      return WORD_MAX;
    end
    if (v < Q_MIN) begin
      return WORD_MIN;
    end
    hit = 1'b0;
    return v[31:0];
  endfunction

  // One filter step: scale the sample, then the bilinear lead-lag update.
  function automatic filt_res_t compensate_sample(input logic [31:0] raw,
                                                  input logic [15:0] dt);
    logic signed [127:0] at_w, bt_w, num;
    logic [127:0] mag, den;
    logic [31:0] scaled_u, scaled_x, y;
    logic hit, clip;
    filt_res_t r;
    scaled_u = clamp32(round_shift(sx32(raw) * sx32(gain_reg)) + sx32(offset_reg), hit);
    clip = hit;
    scaled_x = clamp32(round_shift(sx32(scaled_u) * sx32(lead_reg)), hit);
    clip |= hit;
    at_w = sx32(zero_reg) * $signed({112'd0, dt});
    bt_w = $signed({97'd0, pole_reg}) * $signed({112'd0, dt});
    num = (TWO_Q32 - bt_w) * sx32(prev_filtered)
        + (at_w + TWO_Q32) * sx32(scaled_x)
        + (at_w - TWO_Q32) * sx32(prev_scaled);
    den = TWO_Q32 + bt_w;
    mag = num[127] ? -num : num;
    mag = (mag + (den >> 1)) / den;
    y = clamp32(num[127] ? -$signed(mag) : $signed(mag), hit);
    clip |= hit;
    prev_scaled = scaled_x;
    prev_filtered = y;
    r.value = y;
    r.clip = clip;
    return r;
  endfunction

  function automatic logic [31:0] rand_signed(input int unsigned bits);
    logic [31:0] v;
    v = $urandom_range(0, (32'd1 << bits) - 1);
    return ($urandom_range(1) != 0) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_edge_word();
    case ($urandom_range(5))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return ONE_Q16;
      4: return rand_signed(20);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_time_step();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  task automatic push_sample(input logic [31:0] raw, input logic [15:0] dt);
    sample_item_t it;
    it.raw = raw;
    it.dt = dt;
    pending_samples.insert(pending_samples.size(), it);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_outputs.size() != 0);
  endtask

  task automatic write_reg(input logic [llc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      llc_pkg::CFG_INPUT_GAIN: gain_reg = data;
      llc_pkg::CFG_INPUT_OFFSET: offset_reg = data;
      llc_pkg::CFG_LEAD_GAIN: lead_reg = data;
      llc_pkg::CFG_ZERO_RATE: zero_reg = data;
      llc_pkg::CFG_POLE_RATE: pole_reg = data[30:0];
      default: ;
    endcase
  endtask

  // Writes every register, then junk to an unmapped index that must not land anywhere.
  task automatic apply_settings(input logic [31:0] gain, input logic [31:0] offset,
                                input logic [31:0] lead, input logic [31:0] zero,
                                input logic [31:0] pole);
    wait_idle();
    write_reg(llc_pkg::CFG_INPUT_GAIN, gain);
    write_reg(llc_pkg::CFG_INPUT_OFFSET, offset);
    write_reg(llc_pkg::CFG_LEAD_GAIN, lead);
    write_reg(llc_pkg::CFG_ZERO_RATE, zero);
    write_reg(llc_pkg::CFG_POLE_RATE, pole);
    write_reg(CFG_UNMAPPED, $urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin : sample_driver
    sample_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      if (!in_valid_i || sample_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
          nxt = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          raw_sample_i <= nxt.raw;
          time_step_i <= nxt.dt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    filt_res_t want;
    if (rst_ni) begin
      sample_taken = in_valid_i && in_ready_o;
      // Results are taken first so that an item accepted on the same edge
      // cannot be matched against its own output.
      if (out_valid_o && out_ready_i) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h clipped %b",
                   $time, filtered_value_o, clipped_o);
          mismatch_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (filtered_value_o !== want.value) begin
            $display("%0t: filtered_value expected %h, actual %h",
                     $time, want.value, filtered_value_o);
            mismatch_count++;
          end
          if (clipped_o !== want.clip) begin
            $display("%0t: clipped expected %b, actual %b", $time, want.clip, clipped_o);
            mismatch_count++;
          end
        end
      end
      if (sample_taken) begin
        expected_outputs.insert(expected_outputs.size(),
                                compensate_sample(raw_sample_i, time_step_i));
      end
    end
  end

  initial begin : stimulus
    in_gap_pct = 38;
    out_stall_pct = 65;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: lead gain is zero, so the filter only sees silence.
    push_sample(ONE_Q16, 16'd655);
    push_sample(WORD_MIN, 16'hFFFF);

    // Unity gains and no zero or pole: the output follows the scaled input.
    apply_settings(ONE_Q16, '0, ONE_Q16, '0, '0);
    push_sample(WORD_MAX, 16'h0000);
    push_sample(WORD_MIN, 16'hFFFF);
    push_sample(32'h0000_0001, 16'h0001);

    // A gain of one half puts the scaled samples exactly on a rounding tie.
    apply_settings(32'h0000_8000, '0, ONE_Q16, '0, '0);
    push_sample(32'h0000_0001, 16'd100);
    push_sample(32'hFFFF_FFFF, 16'd100);
    push_sample(32'h0000_0003, 16'd100);
    push_sample(32'hFFFF_FFFD, 16'd100);

    // The first scaling stage saturates high and low.
    apply_settings(WORD_MAX, WORD_MAX, ONE_Q16, ONE_Q16, ONE_Q16);
    push_sample(WORD_MAX, 16'd1000);
    push_sample(WORD_MIN, 16'd1000);
    apply_settings(WORD_MIN, WORD_MIN, NEG_ONE_Q16, NEG_ONE_Q16, ONE_Q16);
    push_sample(WORD_MAX, 16'd1000);
    push_sample(WORD_MIN, 16'd1000);

    // The lead gain alone pushes the scaled input out of range.
    apply_settings(ONE_Q16, '0, WORD_MAX, '0, '0);
    push_sample(32'h0100_0000, 16'd50);
    push_sample(32'hFF00_0000, 16'd50);

    // A far zero with no pole drives the output past range.
    apply_settings(ONE_Q16, '0, ONE_Q16, WORD_MAX, '0);
    push_sample(WORD_MAX, 16'hFFFF);
    push_sample(WORD_MIN, 16'hFFFF);

    // Largest pole against the most negative zero; bit 31 of the pole write is dropped.
    apply_settings(ONE_Q16, '0, ONE_Q16, WORD_MIN, 32'hFFFF_FFFF);
    push_sample(WORD_MAX, 16'hFFFF);
    push_sample(32'h0000_0000, 16'hFFFF);
    push_sample(WORD_MIN, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        in_gap_pct = 65;
        out_stall_pct = 38;
      end else if (ph == 6) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end
      // Most phases keep the filter in a usable range so that its memory matters.
      if (ph % 3 == 1 || ph == 7) begin
        apply_settings(rand_edge_word(), rand_edge_word(), rand_edge_word(),
                       rand_edge_word(), rand_edge_word());
      end else begin
        apply_settings(rand_signed(17), rand_signed(18), rand_signed(18),
                       rand_signed(23), $urandom_range(0, 32'd1 << 23));
      end
      repeat (50) begin
        push_sample(($urandom_range(3) == 0) ? rand_edge_word()
                                             : rand_signed($urandom_range(12, 26)),
                    rand_time_step());
      end
    end

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lead_lag_compensator_unit regression: pass");
    end else begin
      $display("lead_lag_compensator_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("lead_lag_compensator_unit regression: fail");
    $finish;
  end

endmodule

// ===== lead_lag_compensator_unit.f =====
design/llc_pkg.sv
design/llc_mul.sv
design/llc_div.sv
design/llc_datapath.sv
design/llc_ctrl.sv
design/lead_lag_compensator_unit.sv
tb/lead_lag_compensator_unit_tb.sv
